// ===== rtl/core/lch_pkg.sv =====
// Package for the lower convex hull engine: sizes, point record and sequencer states.
// No dependencies.
`default_nettype none
package lch_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = AddrW + 1;
  localparam int XW = 16;
  localparam int EW = 24;
  localparam int PW = XW + EW;
  localparam logic [XW-1:0] OneX = 16'd32768;

  typedef struct packed {
    logic [XW-1:0] x;
    logic signed [EW-1:0] e;
  } point_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SRCH_RD, ST_SRCH_CHK, ST_INSERT, ST_MERGE,
    ST_SORT_I, ST_SORT_RD, ST_SORT_CHK, ST_SORT_PUT,
    ST_HULL_START, ST_HULL_RA, ST_HULL_RB, ST_HULL_RC, ST_HULL_M1, ST_HULL_M2,
    ST_HULL_CMP, ST_REM_RD, ST_REM_WR,
    ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD, ST_SEED0, ST_SEED1
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/lch_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lch_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/lch_mul.sv =====
// Shared signed multiplier with registered product, used for the slope cross products.
// Depends on lch_pkg.
`default_nettype none
module lch_mul
  import lch_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [EW:0]      a,
  input  wire logic signed [XW:0]      b,
  output logic signed [EW+XW+1:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

// ===== rtl/core/lower_convex_hull_engine_core.sv =====
// Top level of the lower convex hull engine: sequencer, point RAM and shared multiplier.
// Depends on lch_pkg, lch_ram and lch_mul.
`default_nettype none
// Points are stored one transaction at a time; each new point is checked against the
// stored points in turn in the point RAM for a duplicate x, one read and one check per
// stored point. A transaction with in_last set then runs an insertion sort (one read and
// one check per shift), the hull sweeps (each slope test uses one registered multiplier
// twice, plus one read and one write per shifted entry on a removal) and emits the hull
// points. in_stall is high throughout; the output register holds each result until
// it is taken. After reset and after each set, ST_SEED0 and ST_SEED1 reseed the store.
module lower_convex_hull_engine_core
  import lch_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [XW-1:0]        in_x,
  input  wire logic signed [EW-1:0] in_energy,
  input  wire logic                 in_last,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [XW-1:0]             out_hull_x,
  output logic signed [EW-1:0]      out_hull_energy,
  output logic                      out_hull_last,
  output logic                      out_overflowed
);
  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic ovf_r, ovf_nxt, last_r, last_nxt, rem_r, rem_nxt;
  point_t pin_r, pin_nxt, a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic signed [EW+XW+1:0] p1_r, p1_nxt;
  logic ov_r, ov_nxt;
  point_t ov_pt_r, ov_pt_nxt;
  logic ov_last_r, ov_last_nxt, ov_ovf_r, ov_ovf_nxt;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  point_t wdata, rdata;
  logic signed [EW:0] ma;
  logic signed [XW:0] mb;
  logic signed [EW+XW+1:0] prod;

  lch_ram #(.Width(PW), .Depth(MaxPoints)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  lch_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(prod));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SEED0;
      ov_r    <= 1'b0;
      cnt_r   <= CntW'(2);
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; last_r <= last_nxt; rem_r <= rem_nxt;
    pin_r <= pin_nxt; a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; p1_r <= p1_nxt;
    ov_pt_r <= ov_pt_nxt; ov_last_r <= ov_last_nxt; ov_ovf_r <= ov_ovf_nxt;
  end

  // Slope terms: left = (b-a), right = (c-b).
  always_comb begin
    ma = '0; mb = '0;
    unique case (state_r)
      ST_HULL_M1: begin
        ma = (EW+1)'(c_r.e) - (EW+1)'(b_r.e);
        mb = $signed({1'b0, b_r.x}) - $signed({1'b0, a_r.x});
      end
      ST_HULL_M2: begin
        ma = (EW+1)'(b_r.e) - (EW+1)'(a_r.e);
        mb = $signed({1'b0, c_r.x}) - $signed({1'b0, b_r.x});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    priority case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_SRCH_RD;
      ST_SRCH_RD:  state_nxt = (i_r == cnt_r) ? ST_INSERT : ST_SRCH_CHK;
      ST_SRCH_CHK: state_nxt = (rdata.x == pin_r.x) ? ST_MERGE : ST_SRCH_RD;
      ST_INSERT, ST_MERGE: state_nxt = last_r ? ST_SORT_I : ST_IDLE;
      ST_SORT_I:   state_nxt = (i_r >= cnt_r) ? ST_HULL_START : ST_SORT_RD;
      ST_SORT_RD:  state_nxt = (j_r == '0) ? ST_SORT_PUT : ST_SORT_CHK;
      ST_SORT_CHK: state_nxt = (rdata.x > pin_r.x) ? ST_SORT_RD : ST_SORT_PUT;
      ST_SORT_PUT: state_nxt = ST_SORT_I;
      ST_HULL_START: state_nxt = (i_r + CntW'(1) < cnt_r) ? ST_HULL_RA :
                                 (rem_r ? ST_HULL_START : ST_OUT_RD);
      ST_HULL_RA:  state_nxt = ST_HULL_RB;
      ST_HULL_RB:  state_nxt = ST_HULL_RC;
      ST_HULL_RC:  state_nxt = ST_HULL_M1;
      ST_HULL_M1:  state_nxt = ST_HULL_M2;
      ST_HULL_M2:  state_nxt = ST_HULL_CMP;
      ST_HULL_CMP: state_nxt = (p1_r >= prod) ? ST_HULL_START : ST_REM_RD;
      ST_REM_RD:   state_nxt = (j_r + CntW'(1) < cnt_r) ? ST_REM_WR : ST_HULL_START;
      ST_REM_WR:   state_nxt = ST_REM_RD;
      ST_OUT_RD:   state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: if (!ov_r || !out_stall) state_nxt = ST_OUT_RD;
      ST_SEED0:    state_nxt = ST_SEED1;
      ST_SEED1:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_SEED0;
    endcase
    if (state_r == ST_OUT_HOLD && (!ov_r || !out_stall) && i_r == cnt_r)
      state_nxt = ST_SEED0;
  end

  always_comb begin
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; ovf_nxt = ovf_r; last_nxt = last_r;
    rem_nxt = rem_r; pin_nxt = pin_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    p1_nxt = p1_r; ov_pt_nxt = ov_pt_r; ov_last_nxt = ov_last_r; ov_ovf_nxt = ov_ovf_r;
    ov_nxt = ov_r && out_stall;
    we = 1'b0; waddr = '0; wdata = pin_r; raddr = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        pin_nxt = '{x: in_x, e: in_energy};
        last_nxt = in_last;
        i_nxt = '0;
      end
      ST_SRCH_RD: begin
        raddr = i_r[AddrW-1:0];
      end
      ST_SRCH_CHK: begin
        if (rdata.x == pin_r.x) begin
          if (rdata.e > pin_r.e) pin_nxt = pin_r;
          else pin_nxt = rdata;
        end else begin
          i_nxt = i_r + CntW'(1);
        end
      end
      ST_MERGE: begin
        we = 1'b1; waddr = i_r[AddrW-1:0]; wdata = pin_r;
        i_nxt = CntW'(1);
      end
      ST_INSERT: begin
        if (cnt_r < CntW'(MaxPoints)) begin
          we = 1'b1; waddr = cnt_r[AddrW-1:0]; cnt_nxt = cnt_r + CntW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        i_nxt = CntW'(1);
      end
      ST_SORT_I: begin
        raddr = i_r[AddrW-1:0];
        j_nxt = i_r;
        rem_nxt = 1'b0;
        if (i_r >= cnt_r) i_nxt = CntW'(1);
      end
      ST_SORT_RD: begin
        if (j_r == CntW'(0)) begin
        end else raddr = j_r[AddrW-1:0] - AddrW'(1);
        if (j_r == i_r) pin_nxt = rdata;
      end
      ST_SORT_CHK: begin
        if (rdata.x > pin_r.x) begin
          we = 1'b1; waddr = j_r[AddrW-1:0]; wdata = rdata;
          j_nxt = j_r - CntW'(1);
        end
      end
      ST_SORT_PUT: begin
        we = 1'b1; waddr = j_r[AddrW-1:0]; wdata = pin_r;
        i_nxt = i_r + CntW'(1);
      end
      ST_HULL_START: begin
        if (!(i_r + CntW'(1) < cnt_r)) begin
          i_nxt = rem_r ? CntW'(1) : '0;
          rem_nxt = 1'b0;
        end
        raddr = i_r[AddrW-1:0] - AddrW'(1);
      end
      ST_HULL_RA: begin
        raddr = i_r[AddrW-1:0];
        a_nxt = rdata;
      end
      ST_HULL_RB: begin
        raddr = i_r[AddrW-1:0] + AddrW'(1);
        b_nxt = rdata;
      end
      ST_HULL_RC: c_nxt = rdata;
      ST_HULL_M1: c_nxt = c_r;
      ST_HULL_M2: p1_nxt = prod;
      ST_HULL_CMP: begin
        if (p1_r >= prod) i_nxt = i_r + CntW'(1);
        else begin
          j_nxt = i_r; rem_nxt = 1'b1;
        end
      end
      ST_REM_RD: begin
        raddr = j_r[AddrW-1:0] + AddrW'(1);
        if (!(j_r + CntW'(1) < cnt_r)) cnt_nxt = cnt_r - CntW'(1);
      end
      ST_REM_WR: begin
        we = 1'b1; waddr = j_r[AddrW-1:0]; wdata = rdata;
        j_nxt = j_r + CntW'(1);
      end
      ST_OUT_RD: raddr = i_r[AddrW-1:0];
      ST_OUT_WAIT: raddr = i_r[AddrW-1:0];
      ST_OUT_HOLD: begin
        raddr = i_r[AddrW-1:0];
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          ov_pt_nxt = rdata;
          ov_last_nxt = (i_r + CntW'(1) == cnt_r);
          ov_ovf_nxt = ovf_r;
          i_nxt = i_r + CntW'(1);
        end
      end
      ST_SEED0: begin
        we = 1'b1; waddr = '0; wdata = '{x: '0, e: '0};
        cnt_nxt = CntW'(2); ovf_nxt = 1'b0;
      end
      ST_SEED1: begin
        we = 1'b1; waddr = AddrW'(1); wdata = '{x: OneX, e: '0};
      end
      default: ;
    endcase
    if (state_r == ST_OUT_HOLD && (!ov_r || !out_stall) && i_r == cnt_r) begin
      ov_nxt = ov_r && out_stall;
      ov_pt_nxt = ov_pt_r; ov_last_nxt = ov_last_r; ov_ovf_nxt = ov_ovf_r;
      i_nxt = i_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_hull_x      = ov_pt_r.x;
  assign out_hull_energy = ov_pt_r.e;
  assign out_hull_last   = ov_last_r;
  assign out_overflowed  = ov_ovf_r;
endmodule
`default_nettype wire
